/* rtl/lkvc_pkg.sv */
package lkvc_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic                    opcode;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } lkvc_req_t;

  typedef struct packed {
    logic                    hit;
    logic signed [VAL_W-1:0] read_value;
    logic                    evicted;
    logic signed [KEY_W-1:0] evicted_key;
  } lkvc_rsp_t;

endpackage

/* rtl/lkvc_store.sv */
module lkvc_store
  import lkvc_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  input  logic             req_en,
  input  lkvc_req_t        req,
  output lkvc_rsp_t        rsp
);

  localparam int RW = $clog2(ENTRIES);
  localparam int FW = $clog2(ENTRIES + 1);
  localparam int CW = (FW > CAP_W) ? FW : CAP_W;

  logic signed [KEY_W-1:0] keys [ENTRIES];
  logic signed [VAL_W-1:0] vals [ENTRIES];
  logic [RW-1:0]           rank [ENTRIES];
  logic [ENTRIES-1:0]      valid;
  logic [FW-1:0]           fill;
  logic [CAP_W-1:0]        capacity;

  logic [ENTRIES-1:0]      match;
  logic [ENTRIES-1:0]      lru_oh;
  logic [ENTRIES-1:0]      free_vec;
  logic [ENTRIES-1:0]      first_free;
  logic [ENTRIES-1:0]      slot_oh;
  logic                    hit;
  logic                    is_put;
  logic                    insert;
  logic                    evict;
  logic [RW-1:0]           hit_rank;
  logic signed [VAL_W-1:0] hit_value;
  logic signed [KEY_W-1:0] lru_key;
  logic [CW-1:0]           fill_ext;
  logic [CW-1:0]           cap_ext;
  logic [CW-1:0]           eff_cap;
  logic [FW-1:0]           last_rank;

  always_comb begin
    last_rank = fill - FW'(1);
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]  = valid[i] && (keys[i] == req.key);
      lru_oh[i] = valid[i] && (FW'(rank[i]) == last_rank);
    end
  end

  // one-hot selects, so the read muxes are plain or-trees
  always_comb begin
    hit_rank  = '0;
    hit_value = '0;
    lru_key   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_rank  = hit_rank  | (match[i]  ? rank[i] : '0);
      hit_value = hit_value | (match[i]  ? vals[i] : '0);
      lru_key   = lru_key   | (lru_oh[i] ? keys[i] : '0);
    end
  end

  always_comb begin
    hit      = |match;
    is_put   = (req.opcode == OP_PUT);
    insert   = !hit && is_put;
    fill_ext = CW'(fill);
    cap_ext  = CW'(capacity);
    if (cap_ext == '0) begin
      eff_cap = CW'(1);
    end else if (cap_ext > CW'(ENTRIES)) begin
      eff_cap = CW'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
    evict      = insert && (fill != '0) && (fill_ext >= eff_cap);
    free_vec   = ~valid;
    first_free = free_vec & (~free_vec + ENTRIES'(1));
    // an evicting insert reuses the slot it frees
    slot_oh    = evict ? lru_oh : first_free;
  end

  always_comb begin
    rsp.hit         = hit;
    rsp.read_value  = (hit && !is_put) ? hit_value : '0;
    rsp.evicted     = evict;
    rsp.evicted_key = evict ? lru_key : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      fill     <= '0;
      capacity <= CAP_RESET;
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (req_en) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (hit) begin
            if (match[i]) begin
              rank[i] <= '0;
            end else if (valid[i] && (rank[i] < hit_rank)) begin
              rank[i] <= rank[i] + RW'(1);
            end
          end else if (insert) begin
            if (slot_oh[i]) begin
              valid[i] <= 1'b1;
              rank[i]  <= '0;
            end else if (valid[i]) begin
              rank[i] <= rank[i] + RW'(1);
            end
          end
        end
        if (insert && !evict) begin
          fill <= fill + FW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_en) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (hit && match[i] && is_put) begin
          vals[i] <= req.value;
        end else if (insert && slot_oh[i]) begin
          keys[i] <= req.key;
          vals[i] <= req.value;
        end
      end
    end
  end

endmodule

/* rtl/lru_key_value_cache.sv */
// channel | dir | tdata (low bit up)          | tuser
// s_*     | in  | key[31:0], value[63:32]     | opcode (0 get, 1 put)
// m_*     | out | read_value[31:0],           | hit[0], evicted[1]
//         |     | evicted_key[63:32]          |
// cfg_*   | in  | capacity[4:0], written when cfg_we is high
//
// one request per cycle sustained while m_tready does not stall; a request
// sits in the input register, where the parallel key compare and rank
// update run, and its response then leaves from the output register
// rst clears all entries, the fill count and sets capacity to 16
// a stalled m_tready holds the response; the input register still takes a
// request while the output register drains in the same cycle
module lru_key_value_cache
  import lkvc_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CAP_W-1:0]       cfg_wdata,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [KEY_W+VAL_W-1:0] s_tdata,  // key, value
  input  logic                   s_tuser,  // opcode
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [VAL_W+KEY_W-1:0] m_tdata,  // read_value, evicted_key
  output logic [1:0]             m_tuser   // hit, evicted
);

  logic      in_valid;
  lkvc_req_t in_req;
  logic      out_valid;
  lkvc_rsp_t out_rsp;
  lkvc_rsp_t rsp;
  logic      advance;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_req.opcode <= s_tuser;
      in_req.key    <= s_tdata[KEY_W-1:0];
      in_req.value  <= s_tdata[KEY_W+VAL_W-1:KEY_W];
    end
    if (advance) begin
      out_rsp <= rsp;
    end
  end

  lkvc_store #(
    .ENTRIES (ENTRIES)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req_en    (advance),
    .req       (in_req),
    .rsp       (rsp)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_rsp.evicted_key, out_rsp.read_value};
  assign m_tuser  = {out_rsp.evicted, out_rsp.hit};

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import lkvc_pkg::*;

  localparam int NSLOT = 16;
  localparam int DRAIN_CYCLES = 6;
  localparam int POOL_MAX = 24;

  typedef enum {RX_OPEN, RX_COIN, RX_SLOW, RX_PERIODIC} rx_mode_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CAP_W-1:0]       cfg_wdata = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [KEY_W+VAL_W-1:0] s_tdata = '0;   // key, value
  logic                   s_tuser = 1'b0; // opcode
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [VAL_W+KEY_W-1:0] m_tdata;        // read_value, evicted_key
  logic [1:0]             m_tuser;        // hit, evicted

  // cache shadow state
  logic [KEY_W-1:0] slot_key [NSLOT];
  logic [VAL_W-1:0] slot_val [NSLOT];
  bit               slot_used [NSLOT];
  int unsigned      slot_age [NSLOT];
  int unsigned      used_count;
  logic [CAP_W-1:0] cap_reg;

  lkvc_rsp_t        expected_rsp_q [$];
  logic [KEY_W-1:0] key_pool [POOL_MAX];
  int               pool_size;
  int               burst_left;
  int               errors;
  rx_mode_t         rx_mode;
  int               rx_run;

  lru_key_value_cache i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic clear_cache_shadow();
    int i;
    for (i = 0; i < NSLOT; i++) begin
      slot_key[i] = '0;
      slot_val[i] = '0;
      slot_used[i] = 1'b0;
      slot_age[i] = 0;
    end
    used_count = 0;
    cap_reg = CAP_RESET;
  endtask

  // age 0 is the most recent entry
  function automatic lkvc_rsp_t predict_response(lkvc_req_t req);
    lkvc_rsp_t rsp;
    int i, found, victim, free_slot, limit;
    int unsigned old_age;
    rsp = '0;
    found = -1;
    victim = -1;
    free_slot = -1;
    limit = (cap_reg == 0) ? 1 : (cap_reg > NSLOT) ? NSLOT : int'(cap_reg);
    for (i = 0; i < NSLOT; i++)
      if (found < 0 && slot_used[i] && slot_key[i] == req.key) found = i;
    if (found >= 0) begin
      rsp.hit = 1'b1;
      if (req.opcode == OP_GET) rsp.read_value = slot_val[found];
      else slot_val[found] = req.value;
      old_age = slot_age[found];
      for (i = 0; i < NSLOT; i++)
        if (slot_used[i] && i != found && slot_age[i] < old_age) slot_age[i]++;
      slot_age[found] = 0;
    end else if (req.opcode == OP_PUT) begin
      if (used_count >= limit && used_count > 0) begin
        for (i = 0; i < NSLOT; i++)
          if (slot_used[i] && (victim < 0 || slot_age[i] > slot_age[victim])) victim = i;
        rsp.evicted = 1'b1;
        rsp.evicted_key = slot_key[victim];
        slot_used[victim] = 1'b0;
        slot_age[victim] = 0;
        used_count--;
      end
      for (i = 0; i < NSLOT; i++)
        if (free_slot < 0 && !slot_used[i]) free_slot = i;
      if (free_slot >= 0) begin
        for (i = 0; i < NSLOT; i++)
          if (slot_used[i]) slot_age[i]++;
        slot_used[free_slot] = 1'b1;
        slot_key[free_slot] = req.key;
        slot_val[free_slot] = req.value;
        slot_age[free_slot] = 0;
        used_count++;
      end
    end
    return rsp;
  endfunction

  task automatic send_request(input logic op, input logic [KEY_W-1:0] key,
                              input logic [VAL_W-1:0] value);
    lkvc_req_t req;
    int gap;
    req.opcode = op;
    req.key = key;
    req.value = value;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {req.value, req.key};
    s_tuser <= req.opcode;
    do @(posedge clk); while (!s_tready);
    expected_rsp_q.push_back(predict_response(req));
  endtask

  task automatic drain_responses();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    cap_reg = cap;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, pool_size - 1)];
    return $urandom();
  endfunction

  task automatic test_get_put_basics();
    send_request(OP_GET, 32'h0000_0000, 32'h1234_5678);   // miss on empty cache
    send_request(OP_PUT, 32'h0000_0000, 32'h7fff_ffff);
    send_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_PUT, 32'h0000_0000, 32'h8000_0000);   // value update
    send_request(OP_GET, 32'h0000_0000, 32'hffff_ffff);
    send_request(OP_PUT, 32'h8000_0000, 32'hffff_ffff);
    send_request(OP_PUT, 32'h7fff_ffff, 32'h0000_0000);
    send_request(OP_PUT, 32'hffff_ffff, 32'h0000_0001);
    send_request(OP_GET, 32'h8000_0000, 32'h0000_0000);
    send_request(OP_GET, 32'hffff_ffff, 32'h0000_0000);
    send_request(OP_GET, 32'h1234_5678, 32'h0000_0000);
  endtask

  // fill is 4 here, so every new key keeps evicting
  task automatic test_lowered_capacity();
    drain_responses();
    set_capacity(5'd2);
    send_request(OP_PUT, 32'h0000_0055, 32'hdead_beef);
    send_request(OP_PUT, 32'h0000_0066, 32'h0bad_cafe);
    send_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_PUT, 32'hffff_ffff, 32'h5555_aaaa);   // update never evicts
    send_request(OP_GET, 32'h0000_0055, 32'h0000_0000);
    send_request(OP_PUT, 32'h0000_0077, 32'haaaa_5555);
  endtask

  task automatic test_capacity_clamp();
    drain_responses();
    set_capacity(5'd0);   // acts as one entry
    send_request(OP_PUT, 32'h0000_0088, 32'h1111_1111);
    send_request(OP_GET, 32'h0000_0088, 32'h0000_0000);
    drain_responses();
    set_capacity(5'd31);  // acts as the full cache
    send_request(OP_PUT, 32'h0000_0099, 32'h2222_2222);
  endtask

  task automatic run_random_phase(input logic [CAP_W-1:0] cap, input int count);
    int i, eff;
    drain_responses();
    set_capacity(cap);
    eff = (cap == 0) ? 1 : (cap > NSLOT) ? NSLOT : int'(cap);
    pool_size = eff + $urandom_range(2, 8);
    for (i = 0; i < pool_size; i++) key_pool[i] = $urandom();
    for (i = 0; i < count; i++)
      send_request(($urandom_range(0, 99) < 55) ? OP_PUT : OP_GET, pick_key(), $urandom());
  endtask

  task automatic test_random_traffic();
    run_random_phase(5'd31, 200);
    run_random_phase(5'd1, 200);   // lowered well below fill
    run_random_phase(5'd16, 200);
    run_random_phase(5'd8, 200);
    run_random_phase(5'd0, 200);
    run_random_phase(5'd2, 200);
    run_random_phase(5'd16, 200);
    run_random_phase(5'($urandom_range(3, 15)), 200);
  endtask

  // receiver stall pattern, independent of the sender
  always @(negedge clk) begin
    if (rx_run == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_run = $urandom_range(8, 60);
    end
    rx_run--;
    case (rx_mode)
      RX_OPEN: m_tready <= 1'b1;
      RX_COIN: m_tready <= ($urandom_range(0, 1) == 1);
      RX_SLOW: m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= (rx_run % 5) != 0;
    endcase
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    lkvc_rsp_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_rsp_q.size() == 0) begin
        errors++;
        $display("%0t: response with none expected, actual hit %b read_value %h evicted %b key %h",
                 $time, m_tuser[0], m_tdata[31:0], m_tuser[1], m_tdata[63:32]);
      end else begin
        want = expected_rsp_q.pop_front();
        check_field("hit", want.hit, m_tuser[0]);
        check_field("read_value", want.read_value, m_tdata[VAL_W-1:0]);
        check_field("evicted", want.evicted, m_tuser[1]);
        check_field("evicted_key", want.evicted_key, m_tdata[VAL_W+KEY_W-1:VAL_W]);
      end
    end
  end

  initial begin
    errors = 0;
    burst_left = 0;
    rx_run = 0;
    rx_mode = RX_OPEN;
    pool_size = 1;
    clear_cache_shadow();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_get_put_basics();
    test_lowered_capacity();
    test_capacity_clamp();
    test_random_traffic();
    drain_responses();
    if (errors == 0 && expected_rsp_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
